// ===== hdl/ping_pong_log_block_manager_assert.svh =====
// assertion macros for the block's checker
`ifndef PING_PONG_LOG_BLOCK_MANAGER_ASSERT_SVH
`define PING_PONG_LOG_BLOCK_MANAGER_ASSERT_SVH

// concurrent check, quiet while reset is asserted
`define PPLBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define PPLBM_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pplbm_pkg.sv =====
// types and constants of the ping-pong log block manager
package pplbm_pkg;

    localparam int BLOCK_BYTES = 8192;
    localparam int BLOCK_COUNT = 2;
    localparam int BLK_IDX_W   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int LEN_W       = 14;
    localparam int SUM_W       = 15;

    localparam logic [63:0] WINDOW_US = 64'd1000000;

    // request codes
    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_ACQUIRE = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_READY = 2'd1,
        ST_HELD  = 2'd2,
        ST_FILL  = 2'd3
    } blk_status_t;

    typedef blk_status_t blk_status_arr_t [BLOCK_COUNT];
    typedef logic [LEN_W-1:0] blk_len_arr_t [BLOCK_COUNT];

    typedef struct packed {
        logic                 found;
        logic [BLK_IDX_W-1:0] idx;
    } claim_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] line_len;
        logic [3:0]  frame_bytes;
        logic [63:0] now_us;
        logic        block_sel;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic        blk_num;
        logic [13:0] offset_or_len;
        logic [13:0] frame_count;
        logic [31:0] drop_cnt;
        logic [14:0] peak_queue;
        logic [14:0] queue_bytes;
        logic [31:0] win_bytes;
        logic [63:0] received_total;
    } resp_t;

endpackage

// ===== hdl/ping_pong_log_block_manager.sv =====
// Log block manager for one bus: a ping-pong pair of fixed log blocks.
//
// Input channel s_valid/s_ready/s_data carries one request per transaction:
// append a line, acquire the lowest ready block, or release a block.
// Result channel m_valid/m_ready/m_data returns exactly one result per
// request: status, block index and write offset or block length, frame
// count, and the running counters (drops, high-water mark, pending bytes,
// one-second frame byte window, received lines).
//
// m_valid rises once the request has passed the input register and the result
// register: the request sits in the input register while the block-state
// update feeds the result register. One request per cycle is sustained while
// the receiver takes results; the free-block search covers every block in
// parallel inside that single update stage.
// When the receiver stalls, the result register holds and the input register
// keeps one more request, then s_ready drops until m_ready returns.
// Reset clears both valid flags, marks every block free with zero length and
// zero frames, and clears all counters and the window start.
module ping_pong_log_block_manager
    import pplbm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output resp_t m_data
);

    // pipeline registers
    req_t  s_data_reg;
    logic  in_valid_reg;
    resp_t m_data_reg;
    resp_t m_data_next;
    logic  out_valid_reg;
    logic  adv;

    // block and counter state
    blk_len_arr_t    len_reg, len_next;
    blk_len_arr_t    frm_reg, frm_next;
    blk_status_arr_t st_reg, st_next;
    logic [BLK_IDX_W-1:0] fill_reg, fill_next;
    logic [31:0] drops_reg, drops_next;
    logic [SUM_W-1:0] peak_reg, peak_next;
    logic [63:0] rcv_reg, rcv_next;
    logic [31:0] wcnt_reg, wcnt_next;
    logic [63:0] wstart_reg, wstart_next;

    // scratch values of the update
    logic [BLK_IDX_W-1:0] fi;
    logic                 have;
    claim_t               cl;
    logic [SUM_W-1:0]     psum;

    // first free block at or after 'first', wrapping
    function automatic claim_t find_free(blk_status_arr_t st, logic [BLK_IDX_W-1:0] first);
        logic [BLK_IDX_W:0] c;
        claim_t r;
        r = '0;
        for (int k = 0; k < BLOCK_COUNT; k++) begin
            c = {1'b0, first} + (BLK_IDX_W+1)'(k);
            if (c >= (BLK_IDX_W+1)'(BLOCK_COUNT)) begin
                c = c - (BLK_IDX_W+1)'(BLOCK_COUNT);
            end
            if (!r.found && st[c[BLK_IDX_W-1:0]] == ST_FREE) begin
                r.found = 1'b1;
                r.idx   = c[BLK_IDX_W-1:0];
            end
        end
        return r;
    endfunction

    // next block index, wrapping
    function automatic logic [BLK_IDX_W-1:0] wrap_inc(logic [BLK_IDX_W-1:0] i);
        logic [BLK_IDX_W:0] c;
        c = {1'b0, i} + (BLK_IDX_W+1)'(1);
        if (c >= (BLK_IDX_W+1)'(BLOCK_COUNT)) begin
            c = c - (BLK_IDX_W+1)'(BLOCK_COUNT);
        end
        return c[BLK_IDX_W-1:0];
    endfunction

    // total bytes held in all blocks
    function automatic logic [SUM_W-1:0] sum_len(blk_len_arr_t ln);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int k = 0; k < BLOCK_COUNT; k++) begin
            s = s + SUM_W'(ln[k]);
        end
        return s;
    endfunction

    // handshake
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = m_data_reg;

    // one request against the block state
    always_comb begin
        len_next    = len_reg;
        frm_next    = frm_reg;
        st_next     = st_reg;
        fill_next   = fill_reg;
        drops_next  = drops_reg;
        peak_next   = peak_reg;
        rcv_next    = rcv_reg;
        wcnt_next   = wcnt_reg;
        wstart_next = wstart_reg;
        fi          = fill_reg;
        have        = 1'b0;
        cl          = '0;
        psum        = '0;
        m_data_next = '0;

        if (adv) begin
            case (s_data_reg.action)
                ACT_APPEND: begin
                    if (s_data_reg.line_len != '0 &&
                        s_data_reg.line_len <= LEN_W'(BLOCK_BYTES)) begin
                        rcv_next = rcv_reg + 64'd1;
                        // one-second window of frame payload bytes
                        if (wstart_reg == '0 ||
                            (s_data_reg.now_us - wstart_reg) >= WINDOW_US) begin
                            wstart_next = s_data_reg.now_us;
                            wcnt_next   = '0;
                        end
                        wcnt_next = wcnt_next + 32'(s_data_reg.frame_bytes);

                        // find the block being filled or claim a free one
                        have = 1'b1;
                        if (st_next[fi] != ST_FILL) begin
                            cl   = find_free(st_next, fi);
                            have = cl.found;
                            if (cl.found) begin
                                fi           = cl.idx;
                                len_next[fi] = '0;
                                frm_next[fi] = '0;
                                st_next[fi]  = ST_FILL;
                            end
                        end

                        // line does not fit: close block and roll over
                        if (have && ({1'b0, len_next[fi]} + {1'b0, s_data_reg.line_len})
                                    > SUM_W'(BLOCK_BYTES)) begin
                            if (len_next[fi] != '0) begin
                                st_next[fi] = ST_READY;
                            end
                            cl   = find_free(st_next, wrap_inc(fi));
                            have = cl.found;
                            if (cl.found) begin
                                fi           = cl.idx;
                                len_next[fi] = '0;
                                frm_next[fi] = '0;
                                st_next[fi]  = ST_FILL;
                            end
                        end
                        fill_next = fi;

                        if (!have) begin
                            drops_next = drops_reg + 32'd1;
                        end else begin
                            m_data_next.ok            = 1'b1;
                            m_data_next.blk_num       = 1'(fi);
                            m_data_next.offset_or_len = len_next[fi];
                            len_next[fi] = len_next[fi] + s_data_reg.line_len;
                            frm_next[fi] = frm_next[fi] + LEN_W'(1);
                            if (len_next[fi] >= LEN_W'(BLOCK_BYTES)) begin
                                st_next[fi] = ST_READY;
                            end
                            psum = sum_len(len_next);
                            if (psum > peak_reg) begin
                                peak_next = psum;
                            end
                        end
                    end
                end
                ACT_ACQUIRE: begin
                    // lowest ready block goes to the reader
                    for (int k = 0; k < BLOCK_COUNT; k++) begin
                        if (!m_data_next.ok && st_reg[k] == ST_READY) begin
                            st_next[k]                = ST_HELD;
                            m_data_next.ok            = 1'b1;
                            m_data_next.blk_num       = 1'(k);
                            m_data_next.offset_or_len = len_reg[k];
                            m_data_next.frame_count   = frm_reg[k];
                        end
                    end
                end
                ACT_RELEASE: begin
                    if (32'(s_data_reg.block_sel) < 32'(BLOCK_COUNT)) begin
                        st_next[BLK_IDX_W'(s_data_reg.block_sel)]  = ST_FREE;
                        len_next[BLK_IDX_W'(s_data_reg.block_sel)] = '0;
                        frm_next[BLK_IDX_W'(s_data_reg.block_sel)] = '0;
                        m_data_next.ok = 1'b1;
                    end
                end
                default: begin
                    m_data_next.ok = 1'b0;
                end
            endcase

            // counters after the update
            m_data_next.drop_cnt       = drops_next;
            m_data_next.peak_queue     = peak_next;
            m_data_next.queue_bytes    = sum_len(len_next);
            m_data_next.win_bytes      = wcnt_next;
            m_data_next.received_total = rcv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s_data_reg <= s_data;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    // control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < BLOCK_COUNT; k++) begin
                len_reg[k] <= '0;
                frm_reg[k] <= '0;
                st_reg[k]  <= ST_FREE;
            end
            fill_reg   <= '0;
            drops_reg  <= '0;
            peak_reg   <= '0;
            rcv_reg    <= '0;
            wcnt_reg   <= '0;
            wstart_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            len_reg    <= len_next;
            frm_reg    <= frm_next;
            st_reg     <= st_next;
            fill_reg   <= fill_next;
            drops_reg  <= drops_next;
            peak_reg   <= peak_next;
            rcv_reg    <= rcv_next;
            wcnt_reg   <= wcnt_next;
            wstart_reg <= wstart_next;
        end
    end

endmodule

// ===== hdl/pplbm_checker.sv =====
// port-level checker for the log block manager, bound to the top level
`include "ping_pong_log_block_manager_assert.svh"

module pplbm_checker
    import pplbm_pkg::*;
(
    input logic  aclk,
    input logic  aresetn,
    input logic  m_valid,
    input logic  m_ready,
    input resp_t m_data
);

    logic peak_covers;
    logic frames_on_ok;

    // pending bytes within the peak, frame counts only with a good status
    assign peak_covers  = m_data.peak_queue >= m_data.queue_bytes;
    assign frames_on_ok = (m_data.frame_count == 14'd0) || m_data.ok;

    // a stalled result transaction stays offered
    `PPLBM_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result withdrawn")

    // no result shows right after reset
    `PPLBM_ASSERT_ALL(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // the high-water mark never falls below the pending bytes
    `PPLBM_ASSERT(a_high_water, aclk, aresetn, m_valid |-> peak_covers, "pending above peak")

    // a nonzero frame count only comes with a good status
    `PPLBM_ASSERT(a_frames_ok, aclk, aresetn, m_valid |-> frames_on_ok, "frames on failed result")

endmodule

bind ping_pong_log_block_manager pplbm_checker u_pplbm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
